>>> src/aged_first_fit_chunk_allocator_core_assert.svh
// assertion macros used by the checker file
`ifndef AGED_FIRST_FIT_CHUNK_ALLOCATOR_CORE_ASSERT_SVH
`define AGED_FIRST_FIT_CHUNK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afa check failed");

// next-cycle implication, sampled on clk, off during reset
`define AFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afa check failed");

`endif

>>> src/afa_pkg.sv
// shared types and constants of the chunk allocator
package afa_pkg;

	localparam int PAGE_W    = 20;
	localparam int REF_W     = 16;
	localparam int OUT_OFF_W = 24;

	localparam logic [PAGE_W-1:0] PAGE_MAX = '1;
	localparam logic [REF_W-1:0]  REF_MAX  = '1;

	// request kinds
	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// response status codes
	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_NEW      = 2'd1;
	localparam logic [1:0] ST_NOROOM   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// fixed-width part of one chunk entry
	typedef struct packed {
		logic              in_use;
		logic [31:0]       key;
		logic [31:0]       epoch;
		logic [31:0]       mtime;
		logic [PAGE_W-1:0] pages;
		logic [REF_W-1:0]  refs;
	} slot_fix_t;

	// chain moves: rotate, pop head, append, rewrite tail
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ROT,
		CELL_POP,
		CELL_PUSH,
		CELL_WTAIL
	} cell_op_t;

	typedef struct packed {
		cell_op_t  op;
		slot_fix_t fix;
	} cell_ctl_t;

	typedef struct packed {
		logic              req_type;
		logic [31:0]       file_key;
		logic [31:0]       file_epoch;
		logic [31:0]       file_mtime;
		logic [PAGE_W-1:0] page_count;
		logic [23:0]       release_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] chunk_offset;
	} rsp_t;

endpackage

>>> src/afa_cell.sv
// one chunk entry of the chain; shifts toward the head or takes the push bus
module afa_cell #(
	parameter int INDEX       = 0,
	parameter int LEN_W       = 7,
	parameter int OFFSET_BITS = 24,
	parameter int AGE_BITS    = 32
) (
	input  logic                     clk,
	input  afa_pkg::cell_ctl_t       ctl,
	input  logic [LEN_W-1:0]         len,
	input  logic [OFFSET_BITS-1:0]   push_off,
	input  logic [AGE_BITS-1:0]      push_age,
	input  afa_pkg::slot_fix_t       nxt_fix,
	input  logic [OFFSET_BITS-1:0]   nxt_off,
	input  logic [AGE_BITS-1:0]      nxt_age,
	output afa_pkg::slot_fix_t       fix,
	output logic [OFFSET_BITS-1:0]   off,
	output logic [AGE_BITS-1:0]      age
);

	afa_pkg::slot_fix_t     fix_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [AGE_BITS-1:0]    age_q;
	logic                   in_body;
	logic                   is_tail;
	logic                   is_end;

	// position of this cell against the live length
	assign in_body = LEN_W'(INDEX + 1) < len;
	assign is_tail = LEN_W'(INDEX + 1) == len;
	assign is_end  = LEN_W'(INDEX) == len;

	// entry storage
	always_ff @(posedge clk) begin
		case (ctl.op)
			afa_pkg::CELL_ROT: begin
				if (in_body) begin
					fix_q <= nxt_fix;
					off_q <= nxt_off;
					age_q <= nxt_age;
				end else if (is_tail) begin
					fix_q <= ctl.fix;
					off_q <= push_off;
					age_q <= push_age;
				end
			end
			afa_pkg::CELL_POP: begin
				if (in_body) begin
					fix_q <= nxt_fix;
					off_q <= nxt_off;
					age_q <= nxt_age;
				end
			end
			afa_pkg::CELL_PUSH: begin
				if (is_end) begin
					fix_q <= ctl.fix;
					off_q <= push_off;
					age_q <= push_age;
				end
			end
			afa_pkg::CELL_WTAIL: begin
				if (is_tail) begin
					fix_q <= ctl.fix;
					off_q <= push_off;
					age_q <= push_age;
				end
			end
			default: begin
			end
		endcase
	end

	assign fix = fix_q;
	assign off = off_q;
	assign age = age_q;

endmodule

>>> src/afa_ctrl.sv
// sequencer: streams the chain through the head for lookup, aging, merge and fit
module afa_ctrl #(
	parameter int MAX_CHUNKS  = 64,
	parameter int OFFSET_BITS = 24,
	parameter int AGE_BITS    = 32,
	parameter int LEN_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  afa_pkg::req_t          req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output afa_pkg::rsp_t          rsp,
	output afa_pkg::cell_ctl_t     ctl,
	output logic [LEN_W-1:0]       len,
	output logic [OFFSET_BITS-1:0] push_off,
	output logic [AGE_BITS-1:0]    push_age,
	input  afa_pkg::slot_fix_t     head_fix,
	input  logic [OFFSET_BITS-1:0] head_off,
	input  logic [AGE_BITS-1:0]    head_age
);

	localparam int SUM_W  = (OFFSET_BITS > afa_pkg::PAGE_W ? OFFSET_BITS : afa_pkg::PAGE_W) + 2;
	localparam int OFFW   = OFFSET_BITS > afa_pkg::OUT_OFF_W ? OFFSET_BITS : afa_pkg::OUT_OFF_W;
	localparam logic [SUM_W-1:0]    OFF_LIMIT = SUM_W'(1) << OFFSET_BITS;
	localparam logic [AGE_BITS-1:0] AGE_MSB   = {1'b1, {(AGE_BITS-1){1'b0}}};
	localparam logic [LEN_W-1:0]    LEN_FULL  = LEN_W'(MAX_CHUNKS);
	localparam logic [LEN_W-1:0]    LEN_ONE   = LEN_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HIT,
		S_REL,
		S_AGE,
		S_FIT,
		S_EMPTY,
		S_DONE
	} state_t;

	state_t                        state_q, state_d;
	logic [LEN_W-1:0]              total_q, total_d;
	logic [LEN_W-1:0]              cnt_q, cnt_d;
	logic                          found_q, found_d;
	logic                          fail_q, fail_d;
	logic [1:0]                    res_status_q, res_status_d;
	logic [OFFSET_BITS-1:0]        res_off_q, res_off_d;
	afa_pkg::slot_fix_t            pend_fix_q, pend_fix_d;
	logic [OFFSET_BITS-1:0]        pend_off_q, pend_off_d;
	logic [AGE_BITS-1:0]           pend_age_q, pend_age_d;
	logic                          pend_v_q, pend_v_d;
	logic                          ins_v_q, ins_v_d;
	logic [OFFSET_BITS-1:0]        ins_off_q, ins_off_d;
	logic [afa_pkg::PAGE_W-1:0]    ins_pages_q, ins_pages_d;
	logic                          last_used_q, last_used_d;
	logic [OFFSET_BITS-1:0]        last_off_q, last_off_d;
	logic [SUM_W-1:0]              last_end_q, last_end_d;
	logic [31:0]                   key_q, key_d;
	logic [31:0]                   epoch_q, epoch_d;
	logic [31:0]                   mtime_q, mtime_d;
	logic [afa_pkg::PAGE_W-1:0]    need_q, need_d;
	logic [23:0]                   roff_q, roff_d;
	logic                          rsp_valid_q, rsp_valid_d;
	afa_pkg::rsp_t                 rsp_q, rsp_d;

	logic                          hit_m;
	logic                          rel_m;
	logic                          fits;
	logic                          merge_ok;
	logic                          full;
	afa_pkg::slot_fix_t            aged_fix;
	logic [AGE_BITS-1:0]           aged_age;
	afa_pkg::slot_fix_t            alloc_fix;
	afa_pkg::slot_fix_t            rem_fix;
	logic [SUM_W-1:0]              head_split;
	logic [SUM_W-1:0]              tail_grow;
	logic [SUM_W-1:0]              tail_app;
	logic [afa_pkg::PAGE_W:0]      merge_sum;
	logic [OFFW-1:0]               res_off_ext;

	// per-head decisions
	always_comb begin
		hit_m = head_fix.in_use && head_fix.epoch == epoch_q && head_fix.mtime == mtime_q &&
			need_q <= head_fix.pages && head_fix.key == key_q;
		rel_m = head_fix.in_use && (OFFW'(head_off) == OFFW'(roff_q));
		fits  = !head_fix.in_use && head_fix.pages >= need_q;
		full  = total_q >= LEN_FULL;

		// aging of the entry leaving the head
		aged_fix = head_fix;
		aged_age = head_age;
		if (head_fix.in_use && head_fix.refs == '0 && head_age == '0) begin
			aged_fix.in_use = 1'b0;
			aged_fix.epoch  = '0;
		end else begin
			aged_age = head_age >> 1;
		end

		merge_sum = {1'b0, pend_fix_q.pages} + {1'b0, aged_fix.pages};
		merge_ok  = !pend_fix_q.in_use && !aged_fix.in_use &&
			merge_sum <= {1'b0, afa_pkg::PAGE_MAX};

		alloc_fix.in_use = 1'b1;
		alloc_fix.key    = key_q;
		alloc_fix.epoch  = epoch_q;
		alloc_fix.mtime  = mtime_q;
		alloc_fix.pages  = need_q;
		alloc_fix.refs   = afa_pkg::REF_W'(1);

		rem_fix        = '0;
		rem_fix.pages  = head_fix.pages - need_q;

		head_split = SUM_W'(head_off) + SUM_W'(need_q);
		tail_grow  = SUM_W'(last_off_q) + SUM_W'(need_q);
		tail_app   = last_end_q + SUM_W'(need_q);
	end

	// sequencing
	always_comb begin
		state_d      = state_q;
		total_d      = total_q;
		cnt_d        = cnt_q;
		found_d      = found_q;
		fail_d       = fail_q;
		res_status_d = res_status_q;
		res_off_d    = res_off_q;
		pend_fix_d   = pend_fix_q;
		pend_off_d   = pend_off_q;
		pend_age_d   = pend_age_q;
		pend_v_d     = pend_v_q;
		ins_v_d      = ins_v_q;
		ins_off_d    = ins_off_q;
		ins_pages_d  = ins_pages_q;
		last_used_d  = last_used_q;
		last_off_d   = last_off_q;
		last_end_d   = last_end_q;
		key_d        = key_q;
		epoch_d      = epoch_q;
		mtime_d      = mtime_q;
		need_d       = need_q;
		roff_d       = roff_q;
		rsp_valid_d  = rsp_valid_q;
		rsp_d        = rsp_q;
		ctl.op       = afa_pkg::CELL_HOLD;
		ctl.fix      = head_fix;
		push_off     = head_off;
		push_age     = head_age;

		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					key_d   = req.file_key;
					epoch_d = req.file_epoch;
					mtime_d = req.file_mtime;
					need_d  = req.page_count == '0 ? afa_pkg::PAGE_W'(1) : req.page_count;
					roff_d  = req.release_offset;
					found_d = 1'b0;
					fail_d  = 1'b0;
					pend_v_d = 1'b0;
					ins_v_d = 1'b0;
					cnt_d   = total_q;
					if (req.req_type == afa_pkg::REQ_RELEASE) begin
						if (total_q == '0) begin
							res_status_d = afa_pkg::ST_NOTFOUND;
							res_off_d    = '0;
							state_d      = S_DONE;
						end else begin
							state_d = S_REL;
						end
					end else begin
						state_d = total_q == '0 ? S_EMPTY : S_HIT;
					end
				end
			end
			S_HIT: begin
				ctl.op = afa_pkg::CELL_ROT;
				if (!found_q && hit_m) begin
					ctl.fix.refs = head_fix.refs == afa_pkg::REF_MAX ? head_fix.refs
						: head_fix.refs + afa_pkg::REF_W'(1);
					push_age  = head_age | AGE_MSB;
					found_d   = 1'b1;
					res_off_d = head_off;
				end
				cnt_d = cnt_q - LEN_ONE;
				if (cnt_q == LEN_ONE) begin
					if (found_q || hit_m) begin
						res_status_d = afa_pkg::ST_HIT;
						state_d      = S_DONE;
					end else begin
						cnt_d   = total_q;
						state_d = S_AGE;
					end
				end
			end
			S_REL: begin
				ctl.op = afa_pkg::CELL_ROT;
				if (!found_q && rel_m) begin
					if (head_fix.refs != '0) begin
						ctl.fix.refs = head_fix.refs - afa_pkg::REF_W'(1);
					end
					found_d   = 1'b1;
					res_off_d = head_off;
				end
				cnt_d = cnt_q - LEN_ONE;
				if (cnt_q == LEN_ONE) begin
					if (found_q || rel_m) begin
						res_status_d = afa_pkg::ST_HIT;
					end else begin
						res_status_d = afa_pkg::ST_NOTFOUND;
						res_off_d    = '0;
					end
					state_d = S_DONE;
				end
			end
			S_AGE: begin
				// pending entry absorbs free neighbors, the rest stream back
				if (cnt_q == '0) begin
					ctl.op   = afa_pkg::CELL_PUSH;
					ctl.fix  = pend_fix_q;
					push_off = pend_off_q;
					push_age = pend_age_q;
					pend_v_d = 1'b0;
					total_d  = total_q + LEN_ONE;
					cnt_d    = total_q + LEN_ONE;
					found_d  = 1'b0;
					state_d  = S_FIT;
				end else if (!pend_v_q) begin
					ctl.op     = afa_pkg::CELL_POP;
					pend_fix_d = aged_fix;
					pend_off_d = head_off;
					pend_age_d = aged_age;
					pend_v_d   = 1'b1;
					total_d    = total_q - LEN_ONE;
					cnt_d      = cnt_q - LEN_ONE;
				end else if (merge_ok) begin
					ctl.op           = afa_pkg::CELL_POP;
					pend_fix_d.pages = merge_sum[afa_pkg::PAGE_W-1:0];
					total_d          = total_q - LEN_ONE;
					cnt_d            = cnt_q - LEN_ONE;
				end else begin
					ctl.op     = afa_pkg::CELL_ROT;
					ctl.fix    = pend_fix_q;
					push_off   = pend_off_q;
					push_age   = pend_age_q;
					pend_fix_d = aged_fix;
					pend_off_d = head_off;
					pend_age_d = aged_age;
					cnt_d      = cnt_q - LEN_ONE;
				end
			end
			S_FIT: begin
				if (ins_v_q) begin
					// split remainder lands right after the new chunk
					ctl.op   = afa_pkg::CELL_PUSH;
					ctl.fix  = '0;
					ctl.fix.pages = ins_pages_q;
					push_off = ins_off_q;
					push_age = AGE_MSB;
					total_d  = total_q + LEN_ONE;
					ins_v_d  = 1'b0;
				end else if (cnt_q != '0) begin
					ctl.op      = afa_pkg::CELL_ROT;
					last_used_d = head_fix.in_use;
					last_off_d  = head_off;
					last_end_d  = SUM_W'(head_off) + SUM_W'(head_fix.pages);
					if (!found_q && fits) begin
						found_d   = 1'b1;
						res_off_d = head_off;
						if (head_fix.pages > need_q) begin
							if (full) begin
								fail_d = 1'b1;
							end else begin
								ctl.fix     = alloc_fix;
								push_age    = '0;
								ins_v_d     = 1'b1;
								ins_off_d   = head_split[OFFSET_BITS-1:0];
								ins_pages_d = rem_fix.pages;
							end
						end else begin
							ctl.fix  = alloc_fix;
							push_age = '0;
						end
					end
					cnt_d = cnt_q - LEN_ONE;
				end else if (found_q) begin
					res_status_d = fail_q ? afa_pkg::ST_NOROOM : afa_pkg::ST_NEW;
					res_off_d    = fail_q ? '0 : res_off_q;
					state_d      = S_DONE;
				end else if (!last_used_q) begin
					// grow the free tail chunk
					if (tail_grow > OFF_LIMIT) begin
						res_status_d = afa_pkg::ST_NOROOM;
						res_off_d    = '0;
					end else begin
						ctl.op       = afa_pkg::CELL_WTAIL;
						ctl.fix      = alloc_fix;
						push_off     = last_off_q;
						push_age     = '0;
						res_status_d = afa_pkg::ST_NEW;
						res_off_d    = last_off_q;
					end
					state_d = S_DONE;
				end else begin
					// append behind the last chunk
					if (full || tail_app > OFF_LIMIT) begin
						res_status_d = afa_pkg::ST_NOROOM;
						res_off_d    = '0;
					end else begin
						ctl.op       = afa_pkg::CELL_PUSH;
						ctl.fix      = alloc_fix;
						push_off     = last_end_q[OFFSET_BITS-1:0];
						push_age     = '0;
						total_d      = total_q + LEN_ONE;
						res_status_d = afa_pkg::ST_NEW;
						res_off_d    = last_end_q[OFFSET_BITS-1:0];
					end
					state_d = S_DONE;
				end
			end
			S_EMPTY: begin
				if (SUM_W'(need_q) > OFF_LIMIT) begin
					res_status_d = afa_pkg::ST_NOROOM;
				end else begin
					ctl.op       = afa_pkg::CELL_PUSH;
					ctl.fix      = alloc_fix;
					push_off     = '0;
					push_age     = '0;
					total_d      = total_q + LEN_ONE;
					res_status_d = afa_pkg::ST_NEW;
				end
				res_off_d = '0;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d        = 1'b1;
					rsp_d.status       = res_status_q;
					rsp_d.chunk_offset = res_off_ext[afa_pkg::OUT_OFF_W-1:0];
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_off_ext = OFFW'(res_off_q);

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			fail_q       <= 1'b0;
			pend_v_q     <= 1'b0;
			ins_v_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			total_q      <= total_d;
			cnt_q        <= cnt_d;
			found_q      <= found_d;
			fail_q       <= fail_d;
			pend_v_q     <= pend_v_d;
			ins_v_q      <= ins_v_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_off_q    <= res_off_d;
		pend_fix_q   <= pend_fix_d;
		pend_off_q   <= pend_off_d;
		pend_age_q   <= pend_age_d;
		ins_off_q    <= ins_off_d;
		ins_pages_q  <= ins_pages_d;
		last_used_q  <= last_used_d;
		last_off_q   <= last_off_d;
		last_end_q   <= last_end_d;
		key_q        <= key_d;
		epoch_q      <= epoch_d;
		mtime_q      <= mtime_d;
		need_q       <= need_d;
		roff_q       <= roff_d;
		rsp_q        <= rsp_d;
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign len       = total_q;

endmodule

>>> src/aged_first_fit_chunk_allocator_core.sv
// top level: chain of chunk cells driven by the sequencer
//
// Usage: one request channel (req_valid, req_stall, req) and one response
// channel (rsp_valid, rsp_stall, rsp). A beat moves when valid is high and
// stall is low. Each request beat gives exactly one response beat, in order.
// The chunk table lives in a chain of MAX_CHUNKS cells; every pass streams
// the T live entries through the head cell, one entry per cycle.
// Release and acquire hit: one lookup pass, then the response beat.
// Acquire miss: lookup, aging and merge, first fit over the aged table
// (one more step for a split), then the response beat.
// Only one request is in flight; req_stall is high from the request beat
// until the response is loaded into the output register.
// Reset clears the table to empty at once, no sweep needed.
// A stalled response holds in the output register; a finished request
// waits for it to drain before the next request is taken.
module aged_first_fit_chunk_allocator_core #(
	parameter int MAX_CHUNKS  = 64,
	parameter int OFFSET_BITS = 24,
	parameter int AGE_BITS    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  afa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output afa_pkg::rsp_t rsp
);

	localparam int LEN_W = $clog2(MAX_CHUNKS + 1);

	afa_pkg::cell_ctl_t     ctl;
	logic [LEN_W-1:0]       len;
	logic [OFFSET_BITS-1:0] push_off;
	logic [AGE_BITS-1:0]    push_age;
	afa_pkg::slot_fix_t     fix_w [MAX_CHUNKS];
	logic [OFFSET_BITS-1:0] off_w [MAX_CHUNKS];
	logic [AGE_BITS-1:0]    age_w [MAX_CHUNKS];

	// sequencer
	afa_ctrl #(
		.MAX_CHUNKS (MAX_CHUNKS),
		.OFFSET_BITS(OFFSET_BITS),
		.AGE_BITS   (AGE_BITS),
		.LEN_W      (LEN_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.ctl      (ctl),
		.len      (len),
		.push_off (push_off),
		.push_age (push_age),
		.head_fix (fix_w[0]),
		.head_off (off_w[0]),
		.head_age (age_w[0])
	);

	// chain of cells, each fed by its right neighbor
	for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
		afa_pkg::slot_fix_t     nf;
		logic [OFFSET_BITS-1:0] no;
		logic [AGE_BITS-1:0]    na;
		if (i + 1 < MAX_CHUNKS) begin : g_mid
			assign nf = fix_w[i+1];
			assign no = off_w[i+1];
			assign na = age_w[i+1];
		end else begin : g_last
			assign nf = '0;
			assign no = '0;
			assign na = '0;
		end
		afa_cell #(
			.INDEX      (i),
			.LEN_W      (LEN_W),
			.OFFSET_BITS(OFFSET_BITS),
			.AGE_BITS   (AGE_BITS)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.len     (len),
			.push_off(push_off),
			.push_age(push_age),
			.nxt_fix (nf),
			.nxt_off (no),
			.nxt_age (na),
			.fix     (fix_w[i]),
			.off     (off_w[i]),
			.age     (age_w[i])
		);
	end

endmodule

>>> src/afa_checker.sv
// port-level checks of the chunk allocator, bound to the top level
`include "aged_first_fit_chunk_allocator_core_assert.svh"

module afa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input afa_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input afa_pkg::rsp_t rsp
);

	logic rsp_fail;

	// response reports a failed request
	assign rsp_fail = rsp.status == afa_pkg::ST_NOROOM || rsp.status == afa_pkg::ST_NOTFOUND;

	// stalled response stays offered
	`AFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

	// stalled response keeps its payload
	`AFA_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp))

	// one request at a time: busy right after a request beat
	`AFA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// failed requests report offset zero
	`AFA_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_fail, rsp.chunk_offset == '0)

endmodule

bind aged_first_fit_chunk_allocator_core afa_checker u_afa_checker (.*);

>>> tb/aged_first_fit_chunk_allocator_core_tb.sv
// testbench for the aged first-fit chunk allocator core
module aged_first_fit_chunk_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 64;
	localparam longint OFF_LIM = 64'd1 << 24;
	localparam logic [31:0] AGE_TOP = 32'h8000_0000;
	localparam int WATCH_LIMIT = 20000;

	// chunk table mirror
	typedef struct {
		bit          used;
		bit [31:0]   key;
		bit [31:0]   epoch;
		bit [31:0]   mtime;
		longint      offset;
		int unsigned pages;
		int unsigned refs;
		bit [31:0]   age;
	} chunk_t;

	class chunk_scoreboard;
		chunk_t        tbl[NSLOT+1];
		int            live;
		afa_pkg::rsp_t pending[$];
		int            errors;

		function void clear();
			chunk_t z;
			z = '{default: 0};
			foreach (tbl[i]) tbl[i] = z;
			live = 0;
		endfunction

		function void make_free(int i, longint off, int unsigned pg, bit [31:0] ag);
			tbl[i] = '{default: 0};
			tbl[i].offset = off;
			tbl[i].pages = pg;
			tbl[i].age = ag;
		endfunction

		function void age_and_coalesce();
			int i;
			for (i = 0; i < live; i++) begin
				if (tbl[i].used && tbl[i].refs == 0 && tbl[i].age == 0) begin
					tbl[i].used = 0;
					tbl[i].epoch = 0;
				end else begin
					tbl[i].age = tbl[i].age >> 1;
				end
			end
			i = 0;
			while (i + 1 < live) begin
				if (!tbl[i].used && !tbl[i+1].used &&
						tbl[i].pages + tbl[i+1].pages <= 32'hFFFFF) begin
					tbl[i].pages += tbl[i+1].pages;
					for (int j = i + 1; j + 1 < live; j++) tbl[j] = tbl[j+1];
					live--;
				end else begin
					i++;
				end
			end
		endfunction

		function afa_pkg::rsp_t acquire(afa_pkg::req_t r);
			afa_pkg::rsp_t o;
			int unsigned need;
			int pick;
			bit found;
			int last;
			longint tail_end;
			need = r.page_count;
			if (need == 0) need = 1;
			for (int i = 0; i < live; i++)
				if (tbl[i].used && tbl[i].epoch == r.file_epoch &&
						tbl[i].mtime == r.file_mtime && need <= tbl[i].pages &&
						tbl[i].key == r.file_key) begin
					tbl[i].age |= AGE_TOP;
					if (tbl[i].refs < 32'hFFFF) tbl[i].refs++;
					o.status = afa_pkg::ST_HIT;
					o.chunk_offset = tbl[i].offset[23:0];
					return o;
				end
			age_and_coalesce();
			o.status = afa_pkg::ST_NOROOM;
			o.chunk_offset = '0;
			if (live == 0) begin
				make_free(0, 0, need, 0);
				live = 1;
			end
			found = 0;
			pick = 0;
			for (int i = 0; i < live; i++)
				if (!found && !tbl[i].used && tbl[i].pages >= need) begin
					pick = i;
					found = 1;
				end
			if (!found) begin
				last = live - 1;
				if (!tbl[last].used) begin
					if (tbl[last].offset + need > OFF_LIM) return o;
					tbl[last].pages = need;
					pick = last;
				end else begin
					tail_end = tbl[last].offset + tbl[last].pages;
					if (live >= NSLOT || tail_end + need > OFF_LIM) return o;
					make_free(live, tail_end, need, 0);
					pick = live;
					live++;
				end
			end
			if (tbl[pick].pages > need) begin
				if (live >= NSLOT) return o;
				for (int j = live; j > pick + 1; j--) tbl[j] = tbl[j-1];
				make_free(pick + 1, tbl[pick].offset + need, tbl[pick].pages - need,
					AGE_TOP);
				live++;
				tbl[pick].pages = need;
			end
			tbl[pick].used = 1;
			tbl[pick].key = r.file_key;
			tbl[pick].epoch = r.file_epoch;
			tbl[pick].mtime = r.file_mtime;
			tbl[pick].refs = 1;
			tbl[pick].age = 0;
			o.status = afa_pkg::ST_NEW;
			o.chunk_offset = tbl[pick].offset[23:0];
			return o;
		endfunction

		function afa_pkg::rsp_t release_ref(afa_pkg::req_t r);
			afa_pkg::rsp_t o;
			for (int i = 0; i < live; i++)
				if (tbl[i].used && tbl[i].offset == r.release_offset) begin
					if (tbl[i].refs > 0) tbl[i].refs--;
					o.status = afa_pkg::ST_HIT;
					o.chunk_offset = r.release_offset;
					return o;
				end
			o.status = afa_pkg::ST_NOTFOUND;
			o.chunk_offset = '0;
			return o;
		endfunction

		// note an accepted request beat
		function void note_request(afa_pkg::req_t r);
			if (r.req_type == afa_pkg::REQ_RELEASE) pending.push_back(release_ref(r));
			else pending.push_back(acquire(r));
		endfunction

		// check one response beat
		function void check_response(afa_pkg::rsp_t got);
			afa_pkg::rsp_t exp;
			if (pending.size() == 0) begin
				report_mismatch("response with nothing expected", '0, got);
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) report_mismatch("status", exp, got);
			if (got.chunk_offset !== exp.chunk_offset)
				report_mismatch("chunk_offset", exp, got);
		endfunction

		function void report_mismatch(string what, afa_pkg::rsp_t exp, afa_pkg::rsp_t got);
			$display("mismatch %s: expected %0d/%0h got %0d/%0h at %0t", what,
				exp.status, exp.chunk_offset, got.status, got.chunk_offset, $realtime);
			errors++;
		endfunction
	endclass

	logic          clk = 0;
	logic          arst_n = 0;
	logic          req_valid = 0;
	logic          req_stall;
	afa_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 0;
	afa_pkg::rsp_t rsp;

	chunk_scoreboard board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;
	bit [31:0] keys[8];
	longint off_seen[$];

	aged_first_fit_chunk_allocator_core dut (.*);

	always #10 clk = ~clk;

	// receiver stall and response check
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			board.check_response(rsp);
			if (rsp.status == afa_pkg::ST_NEW) off_seen.push_back(longint'(rsp.chunk_offset));
		end
		rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// offer one request beat and wait for its acceptance
	task automatic send_beat(afa_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		req <= r;
		req_valid <= 1;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
		req_valid <= 0;
		// pause with valid low before the next offer
		@(posedge clk);
	endtask

	task automatic send_acquire(bit [31:0] k, bit [31:0] e, bit [31:0] m, bit [19:0] pg);
		afa_pkg::req_t r;
		r = '0;
		r.req_type = afa_pkg::REQ_ACQUIRE;
		r.file_key = k;
		r.file_epoch = e;
		r.file_mtime = m;
		r.page_count = pg;
		r.release_offset = 24'($urandom);
		send_beat(r);
	endtask

	task automatic send_release(bit [23:0] off);
		afa_pkg::req_t r;
		r = '0;
		r.file_key = $urandom;
		r.file_epoch = $urandom;
		r.file_mtime = $urandom;
		r.page_count = 20'($urandom);
		r.req_type = afa_pkg::REQ_RELEASE;
		r.release_offset = off;
		send_beat(r);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic bit [19:0] rand_pages();
		case ($urandom_range(9))
			0: return 20'($urandom);
			1: return '0;
			default: return 20'($urandom_range(1, 40));
		endcase
	endfunction

	// mostly reuse of known files and offsets, some noise
	task automatic random_item();
		int k;
		k = $urandom_range(7);
		case ($urandom_range(9))
			0, 1, 2, 3: send_acquire(keys[k], k, k * 3, 20'($urandom_range(1, 30)));
			4: send_acquire(keys[k], k, k * 3, rand_pages());
			5: send_acquire($urandom, $urandom, $urandom, rand_pages());
			6, 7, 8: begin
				if (off_seen.size() > 0)
					send_release(24'(off_seen[$urandom_range(off_seen.size() - 1)]));
				else
					send_release(24'($urandom_range(50)));
			end
			default: send_release(24'($urandom));
		endcase
	endtask

	initial begin
		board = new();
		board.clear();
		foreach (keys[i]) keys[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, hits, releases, overflow
		send_release(24'd0);
		send_acquire(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
		send_acquire(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd5);
		send_acquire(32'd0, 32'd0, 32'd0, 20'd0);
		send_release(24'd0);
		send_release(24'hFFFFFF);
		send_release(24'd0);
		send_release(24'd0);
		for (int i = 0; i < 16; i++) send_acquire(keys[i % 8], i, 32'd0, 20'hFFFFF);
		drain();

		// random phases with different idle patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 57; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 57; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			for (int n = 0; n < 130; n++) random_item();
			// sender pauses until all responses are back
			drain();
		end

		// long receiver hold-off while requests keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			for (int n = 0; n < 20; n++) random_item();
		join

		drain();
		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
